// ----- sv/ascii_byte_calculator_assert.svh -----
// Assertion helpers for the ASCII byte calculator.
// Both macros sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef ASCII_BYTE_CALCULATOR_ASSERT_SVH
`define ASCII_BYTE_CALCULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ABC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ABC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ABC_ASSERT_IMP(label, ante, cons, msg)
`define ABC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/abc_pkg.sv -----
`timescale 1ns / 1ps
package abc_pkg;

    // Depth of the job queue between the parser and the execution unit.
    localparam int JOB_DEPTH_DEF = 2;

    // ASCII characters and digit offsets.
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_1      = "1";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_UP_A   = "A";
    localparam logic [7:0] CH_UP_F   = "F";
    localparam logic [7:0] CH_LO_A   = "a";
    localparam logic [7:0] CH_LO_F   = "f";
    localparam logic [7:0] CH_UP_B   = "B";
    localparam logic [7:0] CH_LO_B   = "b";
    localparam logic [7:0] CH_UP_H   = "H";
    localparam logic [7:0] CH_LO_H   = "h";
    localparam logic [7:0] DIG_OFS   = 8'd48;
    localparam logic [7:0] UPPER_OFS = 8'd55;
    localparam logic [7:0] LOWER_OFS = 8'd87;
    localparam logic [7:0] DEC_BASE  = 8'd10;

    typedef enum logic [1:0] {
        CMD_OPND_A = 2'd0,
        CMD_OPND_B = 2'd1,
        CMD_EXEC   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PARSE = 2'd1,
        ST_DIV0  = 2'd2,
        ST_BADOP = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        PH_SIGN   = 2'd0,
        PH_PREFIX = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_BAD = 3'd4
    } op_class_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_CONV = 2'd2,
        BK_EMIT = 2'd3
    } bk_state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] text_in;
        logic [7:0] op_char;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [7:0] result_value;
        logic [7:0]        text_out;
        logic              last;
    } out_item_t;

    // One execute, classified and with both operand values resolved.
    typedef struct packed {
        op_class_t  op;
        logic       perr;
        logic [7:0] a;
        logic [7:0] b;
    } job_t;

    // Parser state of one operand.
    typedef struct packed {
        logic [7:0] accum;
        logic       negative;
        radix_t     radix;
        phase_t     phase;
        logic       bad;
    } opnd_t;

    localparam opnd_t OPND_RESET = '{
        accum:    8'd0,
        negative: 1'b0,
        radix:    RADIX_DEC,
        phase:    PH_SIGN,
        bad:      1'b0
    };

endpackage

// ----- sv/ascii_byte_calculator.sv -----
`timescale 1ns / 1ps
// Two-operand 8-bit calculator on ASCII text. Each request transaction carries
// one character of the first or second operand, or an execute with an operator
// character; operands may have a leading '-' and a b/B or h/H prefix, otherwise
// they are decimal. A character transaction goes straight into its operand's
// parser register. An execute is resolved by the parser into a job and queued
// (JOB_DEPTH jobs deep), so characters of the next calculation keep flowing
// while the execution unit works. Once the queue is full, full stays high and
// every request transaction waits, characters included. The execution unit
// takes the job, converts the result to decimal digits and sends one response
// transaction per character (one to four). A divide by zero or an unknown
// operator skips the conversion and gives a single status transaction. Division
// runs in the bit-serial restoring divider, one quotient bit per cycle. A ready
// result waits in the output register while the next one is prepared, so with
// pop held high the characters of one result leave back to back.
`include "ascii_byte_calculator_assert.svh"
module ascii_byte_calculator import abc_pkg::*; #(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  request,
    output logic      empty,
    input  logic      pop,
    output out_item_t response
);

    // Parser to queue.
    logic job_push;
    logic job_full;
    job_t wr_job;

    // Queue to execution unit.
    logic job_pop;
    logic job_empty;
    job_t rd_job;

    // Response conditions used by the assertions at the end.
    logic err_rsp;
    logic blank_rsp;
    logic minus_rsp;

    // The front end tracks both operand parsers and resolves operands and the
    // operator class when an execute transaction arrives.
    abc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .job_full (job_full),
        .job_push (job_push),
        .job      (wr_job)
    );

    // Short job queue so the parser and the execution unit stall independently.
    abc_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (wr_job),
        .full   (job_full),
        .pop    (job_pop),
        .rd_job (rd_job),
        .empty  (job_empty)
    );

    // The back end computes the result, formats it and streams the characters.
    abc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (rd_job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .response  (response),
        .empty     (empty),
        .pop       (pop)
    );

    assign err_rsp   = !empty && (response.status == ST_DIV0 || response.status == ST_BADOP);
    assign blank_rsp = response.last && response.text_out == 8'd0
                       && response.result_value == 8'sd0;
    assign minus_rsp = !empty && response.text_out == CH_MINUS;

    // An error status is always a lone, blank final transaction.
    `ABC_ASSERT_IMP(a_err_single, err_rsp, blank_rsp, "error status not a lone blank transaction")

    // A minus sign is never the final character of a result.
    `ABC_ASSERT_IMP(a_minus_not_last, minus_rsp, !response.last, "minus sign marked as last")

    // The parser never pushes a job into a full queue.
    `ABC_ASSERT_IMP(a_no_push_full, job_push, !job_full, "job pushed into a full queue")

    // Characters of one result follow each other without a gap.
    `ABC_ASSERT_NXT(a_no_gap, pop && !empty && !response.last, !empty, "gap inside a result")

endmodule

// ----- sv/abc_front.sv -----
`timescale 1ns / 1ps
module abc_front import abc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t request,
    input  logic     job_full,
    output logic     job_push,
    output job_t     job
);

    opnd_t opnd_reg [2];
    opnd_t opnd_next [2];
    logic  accept;

    // Advance one operand's parser by one character.
    function automatic opnd_t feed(opnd_t s, logic [7:0] c);
        opnd_t      n;
        logic [3:0] d;
        logic       ok;
        logic       done;
        n    = s;
        d    = 4'd0;
        ok   = 1'b0;
        done = s.bad;
        if (!done && n.phase == PH_SIGN)
        begin
            n.phase = PH_PREFIX;
            if (c == CH_MINUS)
            begin
                n.negative = 1'b1;
                done       = 1'b1;
            end
        end
        if (!done && n.phase == PH_PREFIX)
        begin
            n.phase = PH_DIGITS;
            if (c == CH_LO_B || c == CH_UP_B)
            begin
                n.radix = RADIX_BIN;
                done    = 1'b1;
            end
            else if (c == CH_LO_H || c == CH_UP_H)
            begin
                n.radix = RADIX_HEX;
                done    = 1'b1;
            end
            else
            begin
                n.radix = RADIX_DEC;
            end
        end
        if (!done)
        begin
            unique case (n.radix)
                RADIX_BIN:
                begin
                    if (c == CH_0 || c == CH_1)
                    begin
                        d  = 4'(c - DIG_OFS);
                        ok = 1'b1;
                    end
                end
                RADIX_HEX:
                begin
                    if (c >= CH_0 && c <= CH_9)
                    begin
                        d  = 4'(c - DIG_OFS);
                        ok = 1'b1;
                    end
                    else if (c >= CH_UP_A && c <= CH_UP_F)
                    begin
                        d  = 4'(c - UPPER_OFS);
                        ok = 1'b1;
                    end
                    else if (c >= CH_LO_A && c <= CH_LO_F)
                    begin
                        d  = 4'(c - LOWER_OFS);
                        ok = 1'b1;
                    end
                end
                default:
                begin
                    if (c >= CH_0 && c <= CH_9)
                    begin
                        d  = 4'(c - DIG_OFS);
                        ok = 1'b1;
                    end
                end
            endcase
            if (!ok)
            begin
                n.bad = 1'b1;
            end
            else
            begin
                unique case (n.radix)
                    RADIX_BIN: n.accum = {s.accum[6:0], 1'b0} + {4'd0, d};
                    RADIX_HEX: n.accum = {s.accum[3:0], 4'd0} + {4'd0, d};
                    default:   n.accum = {s.accum[4:0], 3'd0} + {s.accum[6:0], 1'b0}
                                         + {4'd0, d};
                endcase
            end
        end
        return n;
    endfunction

    // A bad operand counts as one, without its sign.
    function automatic logic [7:0] opnd_value(opnd_t s);
        if (s.bad)
            return 8'd1;
        if (s.negative)
            return 8'd0 - s.accum;
        return s.accum;
    endfunction

    assign full   = job_full;
    assign accept = push && !full;

    always_comb
    begin
        opnd_next[0] = opnd_reg[0];
        opnd_next[1] = opnd_reg[1];
        job_push     = 1'b0;
        job.a        = opnd_value(opnd_reg[0]);
        job.b        = opnd_value(opnd_reg[1]);
        job.perr     = opnd_reg[0].bad || opnd_reg[1].bad;
        unique case (request.op_char)
            CH_PLUS:  job.op = OP_ADD;
            CH_MINUS: job.op = OP_SUB;
            CH_STAR:  job.op = OP_MUL;
            CH_SLASH: job.op = OP_DIV;
            default:  job.op = OP_BAD;
        endcase
        if (accept)
        begin
            unique case (request.command)
                CMD_OPND_A: opnd_next[0] = feed(opnd_reg[0], request.text_in);
                CMD_OPND_B: opnd_next[1] = feed(opnd_reg[1], request.text_in);
                CMD_EXEC:
                begin
                    job_push     = 1'b1;
                    opnd_next[0] = OPND_RESET;
                    opnd_next[1] = OPND_RESET;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opnd_reg[0] <= OPND_RESET;
            opnd_reg[1] <= OPND_RESET;
        end
        else
        begin
            opnd_reg[0] <= opnd_next[0];
            opnd_reg[1] <= opnd_next[1];
        end
    end

endmodule

// ----- sv/abc_fifo.sv -----
`timescale 1ns / 1ps
module abc_fifo import abc_pkg::*; #(
    parameter int DEPTH = JOB_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    output logic full,
    input  logic pop,
    output job_t rd_job,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ----- sv/abc_back.sv -----
`timescale 1ns / 1ps
module abc_back import abc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      job,
    input  logic      job_empty,
    output logic      job_pop,
    output out_item_t response,
    output logic      empty,
    input  logic      pop
);

    bk_state_t  state_reg, state_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] divisor_reg, divisor_next;
    logic       qneg_reg, qneg_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] r_reg, r_next;
    status_t    status_reg, status_next;
    logic [7:0] char_reg [4];
    logic [7:0] char_next [4];
    logic [1:0] idx_reg, idx_next;
    logic [1:0] last_idx_reg, last_idx_next;
    out_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic        out_free;
    logic [15:0] mul_full;
    logic [8:0]  div_trial;
    logic        div_bit;
    logic [7:0]  q_final;
    logic [7:0]  mag;
    logic        hund;
    logic [6:0]  rem_h;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    logic [1:0]  pos;

    assign empty    = !out_valid_reg;
    assign response = out_reg;
    assign out_free = !out_valid_reg || pop;

    // Datapath pieces shared by the state machine below.
    assign mul_full  = 16'(job.a) * 16'(job.b);
    assign div_trial = {rem_reg, quo_reg[7]};
    assign div_bit   = (div_trial >= {1'b0, divisor_reg});
    assign q_final   = {quo_reg[6:0], div_bit};
    assign mag       = r_reg[7] ? 8'd0 - r_reg : r_reg;
    assign hund      = (mag >= 8'd100);
    assign rem_h     = hund ? 7'(mag - 8'd100) : mag[6:0];
    // Division by ten of a value below 100 through the reciprocal 205 / 2048.
    assign tens_prod = 15'(rem_h) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = rem_h - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        qneg_next      = qneg_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        status_next    = status_reg;
        char_next      = char_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        job_pop        = 1'b0;
        pos            = 2'd0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop     = 1'b1;
                    status_next = job.perr ? ST_PARSE : ST_OK;
                    idx_next    = 2'd0;
                    unique case (job.op)
                        OP_ADD:
                        begin
                            r_next     = job.a + job.b;
                            state_next = BK_CONV;
                        end
                        OP_SUB:
                        begin
                            r_next     = job.a - job.b;
                            state_next = BK_CONV;
                        end
                        OP_MUL:
                        begin
                            r_next     = mul_full[7:0];
                            state_next = BK_CONV;
                        end
                        OP_DIV:
                        begin
                            if (job.b == 8'd0)
                            begin
                                status_next   = ST_DIV0;
                                r_next        = 8'd0;
                                char_next[0]  = 8'd0;
                                last_idx_next = 2'd0;
                                state_next    = BK_EMIT;
                            end
                            else
                            begin
                                quo_next     = job.a[7] ? 8'd0 - job.a : job.a;
                                divisor_next = job.b[7] ? 8'd0 - job.b : job.b;
                                rem_next     = 8'd0;
                                qneg_next    = job.a[7] ^ job.b[7];
                                cnt_next     = 3'd0;
                                state_next   = BK_DIV;
                            end
                        end
                        default:
                        begin
                            status_next   = ST_BADOP;
                            r_next        = 8'd0;
                            char_next[0]  = 8'd0;
                            last_idx_next = 2'd0;
                            state_next    = BK_EMIT;
                        end
                    endcase
                end
            end
            BK_DIV:
            begin
                // One quotient bit per cycle, restoring form on magnitudes.
                rem_next = div_bit ? 8'(div_trial - {1'b0, divisor_reg}) : div_trial[7:0];
                quo_next = q_final;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd7)
                begin
                    r_next     = qneg_reg ? 8'd0 - q_final : q_final;
                    state_next = BK_CONV;
                end
            end
            BK_CONV:
            begin
                if (r_reg[7])
                begin
                    char_next[0] = CH_MINUS;
                    pos          = 2'd1;
                end
                if (hund)
                begin
                    char_next[pos]          = CH_1;
                    char_next[pos + 2'd1]   = DIG_OFS + {4'd0, tens};
                    char_next[pos + 2'd2]   = DIG_OFS + {1'b0, ones};
                    last_idx_next           = pos + 2'd2;
                end
                else if (tens != 4'd0)
                begin
                    char_next[pos]        = DIG_OFS + {4'd0, tens};
                    char_next[pos + 2'd1] = DIG_OFS + {1'b0, ones};
                    last_idx_next         = pos + 2'd1;
                end
                else
                begin
                    char_next[pos] = DIG_OFS + {1'b0, ones};
                    last_idx_next  = pos;
                end
                idx_next   = 2'd0;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.result_value = r_reg;
                    out_next.text_out     = char_reg[idx_reg];
                    out_next.last         = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                        state_next = BK_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 3'd0;
            idx_reg       <= 2'd0;
            last_idx_reg  <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        qneg_reg    <= qneg_next;
        r_reg       <= r_next;
        status_reg  <= status_next;
        char_reg    <= char_next;
        out_reg     <= out_next;
    end

endmodule

// ----- test/ascii_byte_calculator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the ASCII byte calculator. It streams operand
// characters and execute transactions into the block. A scoreboard
// parses the same characters and works out the decimal text that each execute
// should produce. Every response transaction that is popped is compared
// against the oldest predicted character.
module ascii_byte_calculator_tb;
    import abc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 200;
    localparam int IDLE_PERCENT = 31;
    // An execute passes at most through the take, divider, conversion and
    // emit steps, so this leaves ample room.
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 200000;
    localparam int CALM_FROM    = 80;
    localparam int CALM_UNTIL   = 130;
    localparam int DRAIN_AT     = 150;

    // The scoreboard keeps its own copy of both operand parsers and a queue
    // of the response characters that are still owed by the block.
    class calc_scoreboard;
        opnd_t     operand [2];
        out_item_t owed_chars [$];
        int        errors;

        function new();
            operand[0] = OPND_RESET;
            operand[1] = OPND_RESET;
            errors = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t ns] mismatch: %s", $time, what);
            errors++;
        endtask

        function int pending();
            return owed_chars.size();
        endfunction

        // Advances one operand parser by one character.
        function void absorb_char(input int k, input logic [7:0] c);
            logic [7:0] base;
            logic [7:0] digit;
            bit         ok;
            base  = DEC_BASE;
            digit = 8'd0;
            ok    = 1'b0;
            // Once a bad character is seen the operand is frozen.
            if (operand[k].bad)
                return;
            if (operand[k].phase == PH_SIGN)
            begin
                operand[k].phase = PH_PREFIX;
                if (c == CH_MINUS)
                begin
                    operand[k].negative = 1'b1;
                    return;
                end
            end
            if (operand[k].phase == PH_PREFIX)
            begin
                operand[k].phase = PH_DIGITS;
                if (c == CH_LO_B || c == CH_UP_B)
                begin
                    operand[k].radix = RADIX_BIN;
                    return;
                end
                if (c == CH_LO_H || c == CH_UP_H)
                begin
                    operand[k].radix = RADIX_HEX;
                    return;
                end
                operand[k].radix = RADIX_DEC;
            end
            case (operand[k].radix)
                RADIX_BIN:
                begin
                    base = 8'd2;
                    if (c == CH_0 || c == CH_1)
                    begin
                        digit = c - DIG_OFS;
                        ok    = 1'b1;
                    end
                end
                RADIX_HEX:
                begin
                    base = 8'd16;
                    if (c >= CH_0 && c <= CH_9)
                    begin
                        digit = c - DIG_OFS;
                        ok    = 1'b1;
                    end
                    else if (c >= CH_UP_A && c <= CH_UP_F)
                    begin
                        digit = c - UPPER_OFS;
                        ok    = 1'b1;
                    end
                    else if (c >= CH_LO_A && c <= CH_LO_F)
                    begin
                        digit = c - LOWER_OFS;
                        ok    = 1'b1;
                    end
                end
                default:
                begin
                    if (c >= CH_0 && c <= CH_9)
                    begin
                        digit = c - DIG_OFS;
                        ok    = 1'b1;
                    end
                end
            endcase
            if (!ok)
                operand[k].bad = 1'b1;
            else
                operand[k].accum = operand[k].accum * base + digit;
        endfunction

        // A broken operand counts as one, without its sign.
        function logic [7:0] operand_value(input int k);
            if (operand[k].bad)
                return 8'd1;
            if (operand[k].negative)
                return -operand[k].accum;
            return operand[k].accum;
        endfunction

        // Works out the response characters of one execute and restarts both
        // parsers.
        function void predict_execute(input logic [7:0] op);
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] r;
            status_t    st;
            int         dividend;
            int         divisor;
            int         mag;
            int         nd;
            int         digs [3];
            out_item_t  item;
            a  = operand_value(0);
            b  = operand_value(1);
            st = (operand[0].bad || operand[1].bad) ? ST_PARSE : ST_OK;
            operand[0] = OPND_RESET;
            operand[1] = OPND_RESET;
            item = '0;
            r = 8'd0;
            case (op)
                CH_PLUS:  r = a + b;
                CH_MINUS: r = a - b;
                CH_STAR:  r = a * b;
                CH_SLASH:
                begin
                    if (b == 8'd0)
                    begin
                        item.status = ST_DIV0;
                        item.last   = 1'b1;
                        owed_chars.push_back(item);
                        return;
                    end
                    // Integer division truncates toward zero; the most
                    // negative value divided by minus one wraps back onto
                    // itself when cut to eight bits.
                    dividend = $signed(a);
                    divisor  = $signed(b);
                    r = 8'(dividend / divisor);
                end
                default:
                begin
                    item.status = ST_BADOP;
                    item.last   = 1'b1;
                    owed_chars.push_back(item);
                    return;
                end
            endcase
            item.status       = st;
            item.result_value = r;
            mag = $signed(r);
            if (mag < 0)
            begin
                item.text_out = CH_MINUS;
                item.last     = 1'b0;
                owed_chars.push_back(item);
                mag = -mag;
            end
            nd = 0;
            do
            begin
                digs[nd] = mag % 10;
                nd++;
                mag = mag / 10;
            end
            while (mag != 0 && nd < 3);
            while (nd > 0)
            begin
                nd--;
                item.text_out = 8'(CH_0 + digs[nd]);
                item.last     = (nd == 0);
                owed_chars.push_back(item);
            end
        endfunction

        // Called for every request transaction that the block accepts.
        function void note_request(input in_item_t req);
            case (req.command)
                CMD_OPND_A: absorb_char(0, req.text_in);
                CMD_OPND_B: absorb_char(1, req.text_in);
                CMD_EXEC:   predict_execute(req.op_char);
                default:    ;
            endcase
        endfunction

        // Called for every response transaction that is popped.
        task check_response(input out_item_t got);
            out_item_t want;
            if (owed_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response status %0d value %0d text %h",
                                          got.status, got.result_value, got.text_out));
                return;
            end
            want = owed_chars.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, predicted %0d",
                                          got.status, want.status));
            if (got.result_value !== want.result_value)
                report_mismatch($sformatf("result_value %0d, predicted %0d",
                                          got.result_value, want.result_value));
            if (got.text_out !== want.text_out)
                report_mismatch($sformatf("text_out %h, predicted %h",
                                          got.text_out, want.text_out));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, predicted %b", got.last, want.last));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  request;
    logic      empty;
    logic      pop;
    out_item_t response;

    calc_scoreboard sb;
    // While calm is set neither side idles, so the block sees a long
    // stretch of back-to-back transactions in both directions.
    bit calm;
    bit random_phase;
    bit drained;
    int sent_random;
    int cycle_count = 0;

    ascii_byte_calculator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .empty    (empty),
        .pop      (pop),
        .response (response)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing response ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiving side decides at every falling edge whether it pops in
    // the next cycle.
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            pop <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // A response transaction completes at a rising edge with pop high and
    // empty low; the values sampled here are the ones before the edge.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_response(response);
    end

    // Offers one request transaction, with random idle cycles ahead of it,
    // and holds it until the block takes it. Entered and left at a falling
    // edge; push is left high so that the next transaction can follow at
    // once.
    task automatic send_fields(input logic [1:0] cmd, input logic [7:0] text,
                               input logic [7:0] op);
        in_item_t item;
        item.command = cmd;
        item.text_in = text;
        item.op_char = op;
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            // Junk on the data lines while push is low must be ignored.
            push    <= 1'b0;
            request <= in_item_t'($urandom);
            @(negedge clk);
        end
        push    <= 1'b1;
        request <= item;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        sb.note_request(item);
        if (random_phase && cmd != CMD_NOP)
            sent_random++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [1:0] cmd, input logic [7:0] c);
        send_fields(cmd, c, 8'($urandom));
    endtask

    task automatic send_exec(input logic [7:0] op);
        send_fields(CMD_EXEC, 8'($urandom), op);
    endtask

    // Lowers push and waits for every owed response to come back.
    task automatic wait_for_drain();
        push <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Builds the text of one operand: an optional sign, an optional prefix
    // and a few digits of the chosen radix. Now and then a random byte is
    // slipped in, which usually breaks the operand.
    function automatic void build_operand(ref logic [7:0] text [$]);
        int         radix_pick;
        int         ndig;
        int         v;
        logic [7:0] c;
        text.delete();
        if ($urandom_range(2) == 0)
            text.push_back(CH_MINUS);
        radix_pick = $urandom_range(2);
        case (radix_pick)
            1:
            begin
                text.push_back($urandom_range(1) ? CH_LO_B : CH_UP_B);
                ndig = $urandom_range(8);
            end
            2:
            begin
                text.push_back($urandom_range(1) ? CH_LO_H : CH_UP_H);
                ndig = $urandom_range(2);
            end
            default: ndig = $urandom_range(3);
        endcase
        repeat (ndig)
        begin
            case (radix_pick)
                1: c = 8'(CH_0 + $urandom_range(1));
                2:
                begin
                    v = $urandom_range(15);
                    if (v < 10)
                        c = 8'(CH_0 + v);
                    else
                        c = 8'(($urandom_range(1) ? CH_UP_A : CH_LO_A) + v - 10);
                end
                default: c = 8'(CH_0 + $urandom_range(9));
            endcase
            text.push_back(c);
        end
        if ($urandom_range(7) == 0)
            text.insert($urandom_range(text.size()), 8'($urandom_range(255)));
    endfunction

    // A fully random transaction, the unused command included.
    task automatic send_noise();
        send_fields(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // One calculation: the characters of both operands, interleaved at
    // random between the two streams, then an execute.
    task automatic send_calculation();
        logic [7:0] first [$];
        logic [7:0] second [$];
        logic [7:0] op;
        bit         pick_first;
        build_operand(first);
        build_operand(second);
        while (first.size() + second.size() > 0)
        begin
            pick_first = (second.size() == 0) || (first.size() != 0 && $urandom_range(1));
            if (pick_first)
                send_char(CMD_OPND_A, first.pop_front());
            else
                send_char(CMD_OPND_B, second.pop_front());
            if ($urandom_range(19) == 0)
                send_noise();
        end
        case ($urandom_range(8))
            0, 1:    op = CH_PLUS;
            2, 3:    op = CH_MINUS;
            4, 5:    op = CH_STAR;
            6, 7:    op = CH_SLASH;
            default: op = 8'($urandom_range(255));
        endcase
        send_exec(op);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        request      = '0;
        calm         = 1'b0;
        random_phase = 1'b0;
        drained      = 1'b0;
        sent_random  = 0;
        sb = new();
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Both operands empty: zero must print as a single '0'.
        send_exec(CH_PLUS);
        // A lone sign and a lone prefix both count as zero, so this divides
        // by zero.
        send_char(CMD_OPND_A, CH_MINUS);
        send_char(CMD_OPND_B, CH_LO_H);
        send_exec(CH_SLASH);
        // Most negative value divided by minus one wraps and prints "-128".
        send_char(CMD_OPND_A, CH_LO_H);
        send_char(CMD_OPND_A, "8");
        send_char(CMD_OPND_A, CH_0);
        send_char(CMD_OPND_B, CH_MINUS);
        send_char(CMD_OPND_B, CH_1);
        send_exec(CH_SLASH);
        // NUL and 0xFF are invalid characters; the unknown operator status
        // wins over the parse error.
        send_char(CMD_OPND_A, 8'h00);
        send_char(CMD_OPND_B, 8'hFF);
        send_exec(8'hFF);
        // Binary with an upper-case prefix times a decimal digit.
        send_char(CMD_OPND_A, CH_UP_B);
        send_char(CMD_OPND_A, CH_1);
        send_char(CMD_OPND_B, "9");
        send_exec(CH_STAR);
        // Hex digit against a broken operand: text still comes out, marked
        // with the parse error status.
        send_char(CMD_OPND_A, CH_UP_H);
        send_char(CMD_OPND_A, CH_LO_F);
        send_char(CMD_OPND_B, "z");
        send_exec(CH_MINUS);
        // Operator code of zero, then the unused command with all ones.
        send_exec(8'h00);
        send_fields(CMD_NOP, 8'hFF, 8'hFF);

        random_phase = 1'b1;
        while (sent_random < RANDOM_ITEMS)
        begin
            calm = (sent_random >= CALM_FROM && sent_random < CALM_UNTIL);
            if ($urandom_range(9) == 0)
                send_noise();
            else
                send_calculation();
            // Once in the run the sender holds off until the block has
            // returned everything it owes.
            if (!drained && sent_random >= DRAIN_AT)
            begin
                drained = 1'b1;
                wait_for_drain();
            end
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
